@@ src/bcs_pkg.sv @@
// Shared types and constants for the byte cosine similarity block.
// Used by every module under src except bcs_fifo; depends on nothing.
package bcs_pkg;

    // Default for the longest vector pair that is accumulated
    localparam int MAX_LEN_DEF = 4096;

    // Q1.16 result: 17 bits, 65536 stands for 1.0
    localparam int SIM_W   = 17;
    localparam int Q_TOP   = 16;
    localparam int FRAC2_W = 32;  // the dot square is scaled by 2^32
    localparam int BIT_W   = 5;   // counts result bits 16 down to 0

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_LONG = 2'd2
    } status_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_ADD,
        BK_CMP,
        BK_OUT
    } back_state_t;

endpackage

@@ src/byte_cosine_similarity.sv @@
// Top level of the byte cosine similarity block.
// Instantiates bcs_front, bcs_fifo and bcs_back; depends on bcs_pkg.
//
// Byte pairs enter at one per cycle while in_stall is low and are summed into
// the dot product and both squared norms; the pair marked last closes the
// vectors and places one job in a two-entry queue. The back end then finds
// the Q1.16 similarity one result bit at a time over 17 bits, and a new pair
// of vectors may follow at once while that runs. Input stalls only when two
// finished vectors wait in the queue. Status is 0 ok, 1 zero vector, 2 more
// than MAX_LEN pairs; on a nonzero status the similarity is 0. Pairs beyond
// MAX_LEN are not summed.
module byte_cosine_similarity #(
    parameter int MAX_LEN = bcs_pkg::MAX_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                byte_a,
    input  logic [7:0]                byte_b,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [bcs_pkg::SIM_W-1:0] similarity,
    output logic [1:0]                status
);
    import bcs_pkg::*;

    localparam int ACC_W = $clog2(MAX_LEN) + 16;
    localparam int JOB_W = 3 * ACC_W + 2;

    logic             push_valid;
    logic             push_full;
    logic             pop_valid;
    logic             back_busy;
    logic [JOB_W-1:0] push_data;
    logic [JOB_W-1:0] pop_data;

    // Front sees the queue full flag as its stall
    bcs_front #(
        .MAX_LEN (MAX_LEN),
        .ACC_W   (ACC_W),
        .JOB_W   (JOB_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_a     (byte_a),
        .byte_b     (byte_b),
        .last       (last),
        .push_valid (push_valid),
        .push_stall (push_full),
        .push_data  (push_data)
    );

    bcs_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_stall  (back_busy),
        .pop_data   (pop_data)
    );

    bcs_back #(
        .MAX_LEN (MAX_LEN),
        .ACC_W   (ACC_W),
        .JOB_W   (JOB_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (pop_valid),
        .job_stall  (back_busy),
        .job_data   (pop_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .similarity (similarity),
        .status     (status)
    );

endmodule

@@ src/bcs_front.sv @@
// Front end: accumulates dot product and both squared norms, one byte pair a cycle unless the queue is full.
// On the last pair it pushes a job word into the queue. Depends on bcs_pkg.
module bcs_front #(
    parameter int MAX_LEN = bcs_pkg::MAX_LEN_DEF,
    parameter int ACC_W   = $clog2(MAX_LEN) + 16,
    parameter int JOB_W   = 3 * ACC_W + 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       byte_a,
    input  logic [7:0]       byte_b,
    input  logic             last,
    output logic             push_valid,
    input  logic             push_stall,
    output logic [JOB_W-1:0] push_data
);
    import bcs_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [ACC_W-1:0] dot_reg, dot_next;
    logic [ACC_W-1:0] norm_a_reg, norm_a_next;
    logic [ACC_W-1:0] norm_b_reg, norm_b_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             too_long_reg, too_long_next;
    logic             accept;
    logic             full_len;
    logic [15:0]      prod_ab, prod_aa, prod_bb;
    status_t          job_status;

    // Hold input while the queue cannot take a job
    assign in_stall = push_stall;
    assign accept   = in_valid && !in_stall;
    assign full_len = (count_reg == CNT_W'(MAX_LEN));

    // Byte products
    assign prod_ab = 16'(byte_a) * 16'(byte_b);
    assign prod_aa = 16'(byte_a) * 16'(byte_a);
    assign prod_bb = 16'(byte_b) * 16'(byte_b);

    // Advance sums, drop pairs beyond the length limit
    always_comb
    begin
        dot_next      = dot_reg;
        norm_a_next   = norm_a_reg;
        norm_b_next   = norm_b_reg;
        count_next    = count_reg;
        too_long_next = too_long_reg || full_len;
        if (!full_len)
        begin
            dot_next    = dot_reg + ACC_W'(prod_ab);
            norm_a_next = norm_a_reg + ACC_W'(prod_aa);
            norm_b_next = norm_b_reg + ACC_W'(prod_bb);
            count_next  = count_reg + CNT_W'(1);
        end
        if (too_long_next)
            job_status = ST_LONG;
        else if (norm_a_next == '0 || norm_b_next == '0)
            job_status = ST_ZERO;
        else
            job_status = ST_OK;
    end

    // Push a job word on the last pair
    assign push_valid = accept && last;
    assign push_data  = {job_status, dot_next, norm_a_next, norm_b_next};

    // Accumulator registers, cleared after each last pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg      <= '0;
            norm_a_reg   <= '0;
            norm_b_reg   <= '0;
            count_reg    <= '0;
            too_long_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                dot_reg      <= '0;
                norm_a_reg   <= '0;
                norm_b_reg   <= '0;
                count_reg    <= '0;
                too_long_reg <= 1'b0;
            end
            else
            begin
                dot_reg      <= dot_next;
                norm_a_reg   <= norm_a_next;
                norm_b_reg   <= norm_b_next;
                count_reg    <= count_next;
                too_long_reg <= too_long_next;
            end
        end
    end

    // Pair count never passes the length limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("pair count beyond limit");

endmodule

@@ src/bcs_fifo.sv @@
// Two-entry job queue between front and back end.
// Self-contained; needs no package.
module bcs_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_full,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_stall,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_full = (fill_reg == 2'd2);
    assign do_push   = push_valid && !push_full;
    assign pop_valid = (fill_reg != 2'd0);
    assign do_pop    = pop_valid && !pop_stall;
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store a job word
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("job queue fill out of range");

endmodule

@@ src/bcs_back.sv @@
// Back end: turns a job word into the Q1.16 similarity by a bit-by-bit search,
// one bit per BK_ADD, BK_CMP pass; holds the result word. Depends on bcs_pkg.
module bcs_back #(
    parameter int MAX_LEN = bcs_pkg::MAX_LEN_DEF,
    parameter int ACC_W   = $clog2(MAX_LEN) + 16,
    parameter int JOB_W   = 3 * ACC_W + 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_valid,
    output logic                      job_stall,
    input  logic [JOB_W-1:0]          job_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [bcs_pkg::SIM_W-1:0] similarity,
    output logic [1:0]                status
);
    import bcs_pkg::*;

    // Wide search word: holds q*q*normA*normB and dot*dot*2^32 with headroom
    localparam int W = 2 * ACC_W + FRAC2_W + 3;

    back_state_t      state_reg, state_next;
    status_t          status_reg, status_next;
    logic [ACC_W-1:0] dot_reg, dot_next;
    logic [ACC_W-1:0] na_reg, na_next;
    logic [ACC_W-1:0] nb_reg, nb_next;
    logic [W-1:0]     d_reg, d_next;       // dot^2 * 2^32
    logic [W-1:0]     u_reg, u_next;       // q^2 * P
    logic [W-1:0]     tsh_reg, tsh_next;   // (q * P) << (b + 1)
    logic [W-1:0]     ps_reg, ps_next;     // P << 2b
    logic [W-1:0]     cand_reg, cand_next; // (q + 2^b)^2 * P
    logic [W-1:0]     tsum_reg, tsum_next; // tsh plus the new bit's term
    logic [SIM_W-1:0] q_reg, q_next;
    logic [BIT_W-1:0] b_reg, b_next;
    logic [2*ACC_W-1:0] prod_n, dot_sq;
    logic             take_bit;
    status_t          in_status;

    assign in_status  = status_t'(job_data[JOB_W-1 -: 2]);
    assign prod_n     = (2*ACC_W)'(na_reg) * (2*ACC_W)'(nb_reg);
    assign dot_sq     = (2*ACC_W)'(dot_reg) * (2*ACC_W)'(dot_reg);
    assign take_bit   = (cand_reg <= d_reg) && !q_reg[Q_TOP];
    assign job_stall  = (state_reg != BK_IDLE);
    assign out_valid  = (state_reg == BK_OUT);
    assign similarity = q_reg;
    assign status     = status_reg;

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        dot_next    = dot_reg;
        na_next     = na_reg;
        nb_next     = nb_reg;
        d_next      = d_reg;
        u_next      = u_reg;
        tsh_next    = tsh_reg;
        ps_next     = ps_reg;
        cand_next   = cand_reg;
        tsum_next   = tsum_reg;
        q_next      = q_reg;
        b_next      = b_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    status_next = in_status;
                    dot_next    = job_data[3*ACC_W-1 -: ACC_W];
                    na_next     = job_data[2*ACC_W-1 -: ACC_W];
                    nb_next     = job_data[ACC_W-1:0];
                    q_next      = '0;
                    state_next  = (in_status == ST_OK) ? BK_MUL : BK_OUT;
                end
            end
            BK_MUL:
            begin
                // Start the search at the top result bit
                d_next     = W'(dot_sq) << FRAC2_W;
                ps_next    = W'(prod_n) << (2 * Q_TOP);
                u_next     = '0;
                tsh_next   = '0;
                b_next     = BIT_W'(Q_TOP);
                state_next = BK_ADD;
            end
            BK_ADD:
            begin
                cand_next  = u_reg + tsh_reg + ps_reg;
                tsum_next  = tsh_reg + (ps_reg << 1);
                state_next = BK_CMP;
            end
            BK_CMP:
            begin
                // Keep the bit if the candidate square still fits and q has not reached 1.0
                if (take_bit)
                begin
                    q_next   = q_reg | (SIM_W'(1) << b_reg);
                    u_next   = cand_reg;
                    tsh_next = tsum_reg >> 1;
                end
                else
                begin
                    tsh_next = tsh_reg >> 1;
                end
                ps_next = ps_reg >> 2;
                b_next  = b_reg - BIT_W'(1);
                state_next = (b_reg == '0) ? BK_OUT : BK_ADD;
            end
            BK_OUT:
            begin
                if (!out_stall)
                    state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        dot_reg    <= dot_next;
        na_reg     <= na_next;
        nb_reg     <= nb_next;
        d_reg      <= d_next;
        u_reg      <= u_next;
        tsh_reg    <= tsh_next;
        ps_reg     <= ps_next;
        cand_reg   <= cand_next;
        tsum_reg   <= tsum_next;
        q_reg      <= q_next;
        b_reg      <= b_next;
    end

    a_sim_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (q_reg <= SIM_W'(1 << Q_TOP)))
        else $error("similarity above one");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_reg != ST_OK) |-> (q_reg == '0))
        else $error("nonzero similarity on error status");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_CMP) |=> (state_reg == BK_ADD || state_reg == BK_OUT))
        else $error("search step left the loop");

endmodule

@@ dv/byte_cosine_similarity_tb.sv @@
// Self-checking testbench for byte_cosine_similarity: streams byte pairs and
// compares every similarity word against a local Q1.16 cosine predictor.
// Depends on bcs_pkg and the byte_cosine_similarity RTL under src.
`timescale 1ns / 100ps

module byte_cosine_similarity_tb;
    import bcs_pkg::*;

    localparam int VEC_MAX     = MAX_LEN_DEF;
    localparam int QUIET_LIMIT = 5000;   // idle cycles before the watchdog trips
    localparam int DRAIN_WAIT  = 100;    // wait before the final check for stray words
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int LONG_LEN    = 150;    // length of the full-scale vector

    typedef struct packed {
        logic [SIM_W-1:0] sim;
        status_t          st;
    } score_t;

    typedef enum int {
        SH_FULL,
        SH_SMALL,
        SH_EQUAL,
        SH_A_ZERO,
        SH_SPARSE,
        SH_SCALED
    } shape_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       byte_a;
    logic [7:0]       byte_b;
    logic             last;
    logic             out_valid;
    logic             out_stall;
    logic [SIM_W-1:0] similarity;
    logic [1:0]       status;

    // Predictor state
    logic [63:0] sum_ab;
    logic [63:0] sum_aa;
    logic [63:0] sum_bb;
    int          pairs_held;
    bit          overflowed;
    score_t      pending_scores[$];

    // Traffic knobs and bookkeeping
    int src_idle_pct;
    int sink_stall_pct;
    int hold_req;
    int hold_left;
    int quiet_cycles;
    int errors;
    int pairs_sent;
    int scores_ok;
    int scores_zero;
    int scores_long;

    byte_cosine_similarity u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_a     (byte_a),
        .byte_b     (byte_b),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .similarity (similarity),
        .status     (status)
    );

    always #1 clk = ~clk;

    // Largest q in [0, 1.0] with q*q*prod <= dot*dot*2^32, one bit at a time
    function automatic logic [SIM_W-1:0] similarity_q16(input logic [63:0] dot,
                                                         input logic [63:0] prod);
        logic [127:0]     rhs;
        logic [127:0]     lhs;
        logic [SIM_W-1:0] q;
        logic [SIM_W-1:0] c;
        int               b;
        rhs = ({64'd0, dot} * {64'd0, dot}) << 32;
        q   = '0;
        for (b = Q_TOP; b >= 0; b--)
        begin
            c = q | (17'd1 << b);
            if (c <= 17'd65536)
            begin
                lhs = {111'd0, c} * {111'd0, c} * {64'd0, prod};
                if (lhs <= rhs)
                    q = c;
            end
        end
        return q;
    endfunction

    // Accumulate one accepted pair; on last, queue the expected word and clear
    task automatic predict_pair(input logic [7:0] a, input logic [7:0] b, input logic l);
        score_t s;
        if (pairs_held >= VEC_MAX)
            overflowed = 1'b1;
        else
        begin
            sum_ab     += 64'(a) * 64'(b);
            sum_aa     += 64'(a) * 64'(a);
            sum_bb     += 64'(b) * 64'(b);
            pairs_held += 1;
        end
        if (l)
        begin
            s.sim = '0;
            if (overflowed)
                s.st = ST_LONG;
            else if (sum_aa == 0 || sum_bb == 0)
                s.st = ST_ZERO;
            else
            begin
                s.st  = ST_OK;
                s.sim = similarity_q16(sum_ab, sum_aa * sum_bb);
            end
            pending_scores = {pending_scores, s};
            sum_ab     = '0;
            sum_aa     = '0;
            sum_bb     = '0;
            pairs_held = 0;
            overflowed = 1'b0;
        end
    endtask

    // Offer one pair after a random gap and hold it until accepted
    task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic l);
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        byte_a   <= a;
        byte_b   <= b;
        last     <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pairs_sent++;
        predict_pair(a, b, l);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain_scores();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
    endtask

    // Send one vector pair of the given length, content picked by shape
    task automatic send_vector(input int len, input shape_t shape);
        logic [7:0] a;
        logic [7:0] b;
        int         i;
        for (i = 0; i < len; i++)
        begin
            a = 8'($urandom_range(255));
            b = 8'($urandom_range(255));
            case (shape)
                SH_SMALL:
                begin
                    a = 8'($urandom_range(3));
                    b = 8'($urandom_range(3));
                end
                SH_EQUAL:  b = a;
                SH_A_ZERO: a = 8'd0;
                SH_SPARSE:
                begin
                    if ($urandom_range(3) != 0) a = 8'd0;
                    if ($urandom_range(3) != 0) b = 8'd0;
                end
                SH_SCALED: b = a >> 1;
                default: ;
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    // Field extremes, orthogonal and parallel vectors, zero vectors
    task automatic test_corner_cases();
        send_pair(8'd255, 8'd255, 1'b1);
        send_pair(8'd0,   8'd0,   1'b1);
        send_pair(8'd0,   8'd5,   1'b1);
        send_pair(8'd7,   8'd0,   1'b1);
        send_pair(8'd1,   8'd1,   1'b1);
        send_pair(8'd255, 8'd0,   1'b0);
        send_pair(8'd0,   8'd255, 1'b1);
        send_pair(8'd1,   8'd255, 1'b0);
        send_pair(8'd255, 8'd1,   1'b1);
        send_pair(8'd1,   8'd2,   1'b0);
        send_pair(8'd2,   8'd4,   1'b0);
        send_pair(8'd3,   8'd6,   1'b1);
        send_pair(8'h55,  8'hAA,  1'b0);
        send_pair(8'hAA,  8'h55,  1'b0);
        send_pair(8'h80,  8'h7F,  1'b1);
        drain_scores();
    endtask

    // A long vector at full-scale bytes, then a long all-zero vector
    task automatic test_long_vectors();
        int i;
        for (i = 0; i < LONG_LEN; i++)
            send_pair(8'd255, 8'd255, i == LONG_LEN - 1);
        for (i = 0; i < 50; i++)
            send_pair(8'd0, 8'd0, i == 49);
        drain_scores();
    endtask

    // Random vectors, mostly short, a few long, under one idle and stall setting
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_pairs);
        int     start;
        int     len;
        shape_t shape;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        start = pairs_sent;
        while (pairs_sent - start < n_pairs)
        begin
            len   = ($urandom_range(9) == 0) ? $urandom_range(200, 41) : $urandom_range(40, 1);
            shape = shape_t'($urandom_range(5));
            send_vector(len, shape);
        end
        drain_scores();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    // Hold the receiver off while short vectors keep coming, so input stalls
    task automatic test_output_backpressure();
        int start;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = HOLD_CYCLES;
        start = pairs_sent;
        while (pairs_sent - start < 60)
            send_vector($urandom_range(3, 1), shape_t'($urandom_range(5)));
        drain_scores();
    endtask

    // Receiver stall: long hold when asked, else random
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin : score_check
        score_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_scores.size() == 0)
            begin
                $display("%0t: unexpected word: similarity %0d status %0d",
                         $time, similarity, status);
                errors++;
            end
            else
            begin
                want = pending_scores.pop_front();
                if (similarity !== want.sim)
                begin
                    $display("%0t: similarity mismatch: expected %0d actual %0d",
                             $time, want.sim, similarity);
                    errors++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.st, status);
                    errors++;
                end
                case (want.st)
                    ST_OK:   scores_ok++;
                    ST_ZERO: scores_zero++;
                    default: scores_long++;
                endcase
            end
        end
    end

    // Watchdog: trip on a long stretch with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d words outstanding",
                         $time, QUIET_LIMIT, pending_scores.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        byte_a         = 8'd0;
        byte_b         = 8'd0;
        last           = 1'b0;
        out_stall      = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        errors         = 0;
        pairs_sent     = 0;
        scores_ok      = 0;
        scores_zero    = 0;
        scores_long    = 0;
        sum_ab         = '0;
        sum_aa         = '0;
        sum_bb         = '0;
        pairs_held     = 0;
        overflowed     = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_cases();
        test_long_vectors();
        test_random_traffic(0, 0, 160);
        test_random_traffic(88, 0, 160);
        test_random_traffic(0, 88, 160);
        test_random_traffic(10, 10, 160);
        test_output_backpressure();

        // let any stray word surface before the verdict
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_scores.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, pending_scores.size());
            errors++;
        end

        $display("Streamed %0d byte pairs; checked %0d ok, %0d zero-vector, %0d over-length words",
                 pairs_sent, scores_ok, scores_zero, scores_long);
        $display("Traffic ran with no gaps, sparse input, heavy output stall and a long hold-off");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/bcs_pkg.sv
src/bcs_front.sv
src/bcs_fifo.sv
src/bcs_back.sv
src/byte_cosine_similarity.sv
dv/byte_cosine_similarity_tb.sv
